// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Holds default sizes, command and status codes, and the cell operation type.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default sizes
    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int PRIO_BITS_DEF    = 8;

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Status codes
    localparam int STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } cell_op_t;

endpackage

// ===== hw/rtl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if: request and response channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface spq_req_if #(
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [PRIO_BITS-1:0]    entry_priority;
    logic [PAYLOAD_BITS-1:0] entry_payload;

    modport source (output valid, output cmd, output entry_priority,
                    output entry_payload, input ready);
    modport sink   (input valid, input cmd, input entry_priority,
                    input entry_payload, output ready);
endinterface

interface spq_rsp_if #(
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int OCC_BITS     = $clog2(spq_pkg::DEPTH_DEF + 1)
);
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::STATUS_BITS-1:0]     status;
    logic [PRIO_BITS-1:0]                out_priority;
    logic [PAYLOAD_BITS-1:0]             out_payload;
    logic [OCC_BITS-1:0]                 occupancy;

    modport source (output valid, output status, output out_priority,
                    output out_payload, output occupancy, input ready);
    modport sink   (input valid, input status, input out_priority,
                    input out_payload, input occupancy, output ready);
endinterface

// ===== hw/rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded sorted priority queue, stable on ties
// A chain of DEPTH cells kept sorted highest priority first.
// ----------------------------------------------------------------------------
// Usage:
//   req carries cmd (push or pop), entry_priority and entry_payload.
//   rsp returns status, out_priority, out_payload and occupancy, one
//   response item for every request item, in order.
//   A push goes behind all held entries of equal or higher priority; a
//   push to a full queue is dropped with a full status. A pop returns the
//   head entry, or an empty status with zero fields when nothing is held.
//   Latency: the response is registered and appears the cycle after the
//   request is taken. Throughput: one item per cycle unless stalled; every
//   cell updates in the same cycle from its own compare and its neighbors'
//   registers. Reset clears all occupancy flags, the occupancy count and the
//   response valid flag; entry storage and response fields are left as is.
//   When the receiver stalls, the response register holds and req.ready
//   drops until it is taken; the next request is taken in the same cycle
//   the waiting response leaves.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int OCC_BITS = $clog2(DEPTH + 1);

    logic [DEPTH-1:0]        cell_valid;
    logic [DEPTH-1:0]        cell_behind;
    logic [PRIO_BITS-1:0]    cell_prio    [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];

    spq_pkg::cell_op_t       op;
    logic                    accept;
    logic                    full;
    logic                    empty;

    logic                                rsp_valid_reg;
    logic                                rsp_valid_next;
    logic [spq_pkg::STATUS_BITS-1:0]     status_reg;
    logic [spq_pkg::STATUS_BITS-1:0]     status_next;
    logic [PRIO_BITS-1:0]                out_prio_reg;
    logic [PRIO_BITS-1:0]                out_prio_next;
    logic [PAYLOAD_BITS-1:0]             out_payload_reg;
    logic [PAYLOAD_BITS-1:0]             out_payload_next;
    logic [OCC_BITS-1:0]                 count_reg;
    logic [OCC_BITS-1:0]                 count_next;

    // Take a request whenever the response register is free or leaving
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = cell_valid[DEPTH-1];
    assign empty     = !cell_valid[0];

    // Decode the operation and build the response
    always_comb
    begin
        op               = spq_pkg::CELL_HOLD;
        count_next       = count_reg;
        status_next      = status_reg;
        out_prio_next    = out_prio_reg;
        out_payload_next = out_payload_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        if (accept)
        begin
            rsp_valid_next   = 1'b1;
            status_next      = spq_pkg::ST_OK;
            out_prio_next    = '0;
            out_payload_next = '0;
            if (req.cmd == spq_pkg::CMD_PUSH)
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    op         = spq_pkg::CELL_PUSH;
                    count_next = count_reg + OCC_BITS'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    op               = spq_pkg::CELL_POP;
                    count_next       = count_reg - OCC_BITS'(1);
                    out_prio_next    = cell_prio[0];
                    out_payload_next = cell_payload[0];
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    // Response payload registers
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        out_prio_reg    <= out_prio_next;
        out_payload_reg <= out_payload_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_priority = out_prio_reg;
    assign rsp.out_payload  = out_payload_reg;
    assign rsp.occupancy    = count_reg;

    // Chain of cells, head at index zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                    prev_valid;
        logic                    prev_behind;
        logic [PRIO_BITS-1:0]    prev_prio;
        logic [PAYLOAD_BITS-1:0] prev_payload;
        logic                    next_valid;
        logic [PRIO_BITS-1:0]    next_prio;
        logic [PAYLOAD_BITS-1:0] next_payload;

        if (i == 0)
        begin : g_head
            assign prev_valid   = 1'b1;
            assign prev_behind  = 1'b0;
            assign prev_prio    = req.entry_priority;
            assign prev_payload = req.entry_payload;
        end
        else
        begin : g_body
            assign prev_valid   = cell_valid[i-1];
            assign prev_behind  = cell_behind[i-1];
            assign prev_prio    = cell_prio[i-1];
            assign prev_payload = cell_payload[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_valid   = 1'b0;
            assign next_prio    = cell_prio[i];
            assign next_payload = cell_payload[i];
        end
        else
        begin : g_link
            assign next_valid   = cell_valid[i+1];
            assign next_prio    = cell_prio[i+1];
            assign next_payload = cell_payload[i+1];
        end

        spq_cell #(
            .PRIO_BITS    (PRIO_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .op           (op),
            .new_prio     (req.entry_priority),
            .new_payload  (req.entry_payload),
            .prev_valid   (prev_valid),
            .prev_behind  (prev_behind),
            .prev_prio    (prev_prio),
            .prev_payload (prev_payload),
            .next_valid   (next_valid),
            .next_prio    (next_prio),
            .next_payload (next_payload),
            .valid        (cell_valid[i]),
            .behind       (cell_behind[i]),
            .prio         (cell_prio[i]),
            .payload      (cell_payload[i])
        );
    end

endmodule

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on a push it keeps, takes the new entry or takes its
// upper neighbor's entry; on a pop it takes its lower neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  spq_pkg::cell_op_t       op,
    input  logic [PRIO_BITS-1:0]    new_prio,
    input  logic [PAYLOAD_BITS-1:0] new_payload,
    input  logic                    prev_valid,
    input  logic                    prev_behind,
    input  logic [PRIO_BITS-1:0]    prev_prio,
    input  logic [PAYLOAD_BITS-1:0] prev_payload,
    input  logic                    next_valid,
    input  logic [PRIO_BITS-1:0]    next_prio,
    input  logic [PAYLOAD_BITS-1:0] next_payload,
    output logic                    valid,
    output logic                    behind,
    output logic [PRIO_BITS-1:0]    prio,
    output logic [PAYLOAD_BITS-1:0] payload
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [PRIO_BITS-1:0]    prio_reg;
    logic [PRIO_BITS-1:0]    prio_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;

    // New entry belongs at or above this slot
    assign behind = !valid_reg || (prio_reg < new_prio);

    // Select next content from the operation and neighbors
    always_comb
    begin
        valid_next   = valid_reg;
        prio_next    = prio_reg;
        payload_next = payload_reg;
        unique case (op)
            spq_pkg::CELL_PUSH:
            begin
                valid_next = valid_reg | prev_valid;
                if (behind)
                begin
                    if (prev_behind)
                    begin
                        prio_next    = prev_prio;
                        payload_next = prev_payload;
                    end
                    else
                    begin
                        prio_next    = new_prio;
                        payload_next = new_payload;
                    end
                end
            end
            spq_pkg::CELL_POP:
            begin
                valid_next   = next_valid;
                prio_next    = next_prio;
                payload_next = next_payload;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry contents
    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign valid   = valid_reg;
    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule
